[hw/rtl/css_pkg.sv]
// ----------------------------------------------------------------------------
// css_pkg
// Shared types and constants of the Colussi string search block.
// ----------------------------------------------------------------------------
package css_pkg;

    // Largest pattern, and the depth of the text ring.
    localparam int PAT_MAX = 256;
    // Width of text positions; received text counting stops at 2**(POS_W-1).
    localparam int POS_W   = 21;

    // Item and result queue geometry.
    localparam int IQ_AW = 2;
    localparam int RQ_AW = 2;

    // Input operation codes.
    localparam logic OP_PAT  = 1'b0;
    localparam logic OP_TEXT = 1'b1;

    typedef logic [8:0]       ix_t;
    typedef logic [7:0]       byte_t;
    typedef logic [POS_W-1:0] pos_t;

    typedef enum logic [1:0] {
        K_PAT,
        K_PAT_LAST,
        K_TEXT,
        K_TEXT_LAST
    } kind_t;

    typedef struct packed {
        kind_t kind;
        byte_t ch;
    } item_t;

    typedef struct packed {
        logic        found;
        logic [19:0] match_start;
        logic        text_done;
        logic        overflow;
    } res_t;

    typedef struct packed {
        logic empty;
        logic full;
        logic room2;
    } rq_stat_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_LOAD,
        PH_SEARCH
    } phase_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CLR,
        ST_HA_RD,
        ST_HA_CMP,
        ST_HW,
        ST_HQ_RD,
        ST_HQ_CMP,
        ST_HEND,
        ST_KM_RD,
        ST_KM_WR,
        ST_RM_RD,
        ST_RM_WR,
        ST_VO_RD,
        ST_VO_WR,
        ST_NHD_LAST,
        ST_SR_VIS,
        ST_SR_TAB,
        ST_SR_NHD,
        ST_SR_WR,
        ST_SEA_V,
        ST_SEA_C,
        ST_SEA_D,
        ST_SEA_T,
        ST_SEA_U
    } state_t;

endpackage

[hw/rtl/colussi_string_search.sv]
// ----------------------------------------------------------------------------
// colussi_string_search
// Exact pattern search by Colussi's method over a streamed text.
// ----------------------------------------------------------------------------
// Pattern bytes are pushed first, the last one marked; text bytes follow and
// each match start is returned in increasing order, with an end-marker result
// after the last text byte. After the last pattern byte the engine builds its
// tables in its table memories and takes no item meanwhile. When a text byte
// completes a window, the engine compares characters paced by the visit,
// pattern and text ring memory reads in turn, and takes no new byte until the
// window is done. The engine also waits while the result queue has room for
// fewer than two results. A four-entry queue on each side lets the input and
// the result consumer stall independently of the engine.
module colussi_string_search
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        op,
    input  logic [7:0]  ch,
    input  logic        is_last,
    output logic        empty,
    input  logic        pop,
    output logic        found,
    output logic [19:0] match_start,
    output logic        text_done,
    output logic        overflow
);

    logic               item_valid;
    css_pkg::item_t     item;
    logic               eng_take;
    logic               res_push;
    css_pkg::res_t      res_wr;
    css_pkg::res_t      res_rd;
    css_pkg::rq_stat_t  rq_stat;

    // Input queue and classification.
    css_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .op         (op),
        .ch         (ch),
        .is_last    (is_last),
        .take       (eng_take),
        .item_valid (item_valid),
        .item       (item)
    );

    // Table build and search engine.
    css_engine u_engine
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .take       (eng_take),
        .room2      (rq_stat.room2),
        .res_push   (res_push),
        .res_data   (res_wr)
    );

    // Result queue.
    css_result_fifo u_results
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (res_push),
        .wr_data (res_wr),
        .pop     (pop),
        .rd_data (res_rd),
        .stat    (rq_stat)
    );

    assign empty       = rq_stat.empty;
    assign found       = res_rd.found;
    assign match_start = res_rd.match_start;
    assign text_done   = res_rd.text_done;
    assign overflow    = res_rd.overflow;

`ifndef SYNTH
    // The engine never pushes into a full result queue.
    a_no_res_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !rq_stat.full)
        else $error("result queue overrun");

    // The engine only takes an item that the front holds.
    a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
        eng_take |-> item_valid)
        else $error("engine took from an empty input queue");

    // An end marker carries no match.
    a_end_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && text_done) |-> (!found && match_start == 20'd0))
        else $error("end marker carries match data");
`endif

endmodule

[hw/rtl/css_front.sv]
// ----------------------------------------------------------------------------
// css_front
// Input queue: accepts items, classifies them and holds them for the engine.
// ----------------------------------------------------------------------------
module css_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  logic            op,
    input  logic [7:0]      ch,
    input  logic            is_last,
    input  logic            take,
    output logic            item_valid,
    output css_pkg::item_t  item
);

    localparam int DEPTH = 2 ** css_pkg::IQ_AW;

    css_pkg::item_t             q_mem [DEPTH];
    logic [css_pkg::IQ_AW-1:0]  wr_ptr_reg;
    logic [css_pkg::IQ_AW-1:0]  wr_ptr_next;
    logic [css_pkg::IQ_AW-1:0]  rd_ptr_reg;
    logic [css_pkg::IQ_AW-1:0]  rd_ptr_next;
    logic [css_pkg::IQ_AW:0]    cnt_reg;
    logic [css_pkg::IQ_AW:0]    cnt_next;
    logic                       wr;
    css_pkg::item_t             new_item;

    // Classify the incoming transaction by operation and end mark.
    always_comb
    begin
        new_item.ch = ch;
        if (op == css_pkg::OP_PAT)
        begin
            new_item.kind = is_last ? css_pkg::K_PAT_LAST : css_pkg::K_PAT;
        end
        else
        begin
            new_item.kind = is_last ? css_pkg::K_TEXT_LAST : css_pkg::K_TEXT;
        end
    end

    assign full       = (cnt_reg == (css_pkg::IQ_AW+1)'(DEPTH));
    assign item_valid = (cnt_reg != '0);
    assign wr         = push && !full;
    assign item       = q_mem[rd_ptr_reg];

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = take ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + (css_pkg::IQ_AW+1)'(wr) - (css_pkg::IQ_AW+1)'(take);
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            q_mem[wr_ptr_reg] <= new_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

[hw/rtl/css_result_fifo.sv]
// ----------------------------------------------------------------------------
// css_result_fifo
// Result queue between the engine and the result ports.
// ----------------------------------------------------------------------------
module css_result_fifo
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr,
    input  css_pkg::res_t      wr_data,
    input  logic               pop,
    output css_pkg::res_t      rd_data,
    output css_pkg::rq_stat_t  stat
);

    localparam int DEPTH = 2 ** css_pkg::RQ_AW;

    css_pkg::res_t              q_mem [DEPTH];
    logic [css_pkg::RQ_AW-1:0]  wr_ptr_reg;
    logic [css_pkg::RQ_AW-1:0]  wr_ptr_next;
    logic [css_pkg::RQ_AW-1:0]  rd_ptr_reg;
    logic [css_pkg::RQ_AW-1:0]  rd_ptr_next;
    logic [css_pkg::RQ_AW:0]    cnt_reg;
    logic [css_pkg::RQ_AW:0]    cnt_next;
    logic                       rd;
    logic                       wr_ok;

    assign stat.empty = (cnt_reg == '0);
    assign stat.full  = (cnt_reg == (css_pkg::RQ_AW+1)'(DEPTH));
    assign stat.room2 = (cnt_reg <= (css_pkg::RQ_AW+1)'(DEPTH - 2));
    assign rd         = pop && !stat.empty;
    assign wr_ok      = wr && !stat.full;
    assign rd_data    = q_mem[rd_ptr_reg];

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = wr_ok ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + (css_pkg::RQ_AW+1)'(wr_ok) - (css_pkg::RQ_AW+1)'(rd);
    end

    always_ff @(posedge clk)
    begin
        if (wr_ok)
        begin
            q_mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

[hw/rtl/css_engine.sv]
// ----------------------------------------------------------------------------
// css_engine
// Back end: pattern store, table build sequencer and the window search.
// ----------------------------------------------------------------------------
module css_engine
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    input  css_pkg::item_t  item,
    output logic            take,
    input  logic            room2,
    output logic            res_push,
    output css_pkg::res_t   res_data
);

    // Table memories.
    logic [7:0] pat_mem    [css_pkg::PAT_MAX];
    logic [7:0] ring_mem   [css_pkg::PAT_MAX];
    logic [8:0] hmax_mem   [css_pkg::PAT_MAX+1];
    logic [8:0] kmin_mem   [css_pkg::PAT_MAX];
    logic [8:0] rmin_mem   [css_pkg::PAT_MAX];
    logic [7:0] visit_mem  [css_pkg::PAT_MAX];
    logic [8:0] nhd_mem    [css_pkg::PAT_MAX+1];
    logic [8:0] shift_mem  [css_pkg::PAT_MAX+1];
    logic [8:0] resume_mem [css_pkg::PAT_MAX+1];

    // Memory ports.
    logic       pat_we;
    logic [7:0] pat_wa, pat_wd, pat_ra0, pat_ra1, pat_rd0, pat_rd1;
    logic       ring_we;
    logic [7:0] ring_wa, ring_wd, ring_ra, ring_rd;
    logic       hmax_we;
    logic [8:0] hmax_wa, hmax_wd, hmax_ra, hmax_rd;
    logic       kmin_we;
    logic [7:0] kmin_wa, kmin_ra;
    logic [8:0] kmin_wd, kmin_rd;
    logic       rmin_we;
    logic [7:0] rmin_wa, rmin_ra;
    logic [8:0] rmin_wd, rmin_rd;
    logic       visit_we;
    logic [7:0] visit_wa, visit_wd, visit_ra, visit_rd;
    logic       nhd_we;
    logic [8:0] nhd_wa, nhd_wd, nhd_ra, nhd_rd;
    logic       shift_we;
    logic [8:0] shift_wa, shift_wd, shift_ra, shift_rd;
    logic       resume_we;
    logic [8:0] resume_wa, resume_wd, resume_ra, resume_rd;

    // Control and search registers.
    css_pkg::state_t state_reg, state_next;
    css_pkg::phase_t phase_reg, phase_next;
    css_pkg::ix_t    len_reg, len_next;
    css_pkg::ix_t    fpe_reg, fpe_next;
    css_pkg::pos_t   ws_reg, ws_next;
    css_pkg::pos_t   rc_reg, rc_next;
    css_pkg::pos_t   lcp_reg, lcp_next;
    css_pkg::ix_t    sp_reg, sp_next;
    logic            ovf_reg, ovf_next;
    logic            last_reg, last_next;
    css_pkg::ix_t    i_reg, i_next;
    // Table build registers.
    css_pkg::ix_t    a_reg, a_next;
    css_pkg::ix_t    k_reg, k_next;
    css_pkg::ix_t    q_reg, q_next;
    css_pkg::ix_t    r_reg, r_next;
    css_pkg::ix_t    lo_reg, lo_next;
    css_pkg::ix_t    hi_reg, hi_next;
    logic [7:0]      v_reg, v_next;
    logic [8:0]      rmin0_reg, rmin0_next;

    // Shared conditions.
    logic            itm_pat;
    logic            itm_last;
    logic            searching;
    logic            rc_room;
    css_pkg::pos_t   rc_after;
    logic            win;
    logic [9:0]      hq_sum;
    logic            hq_less;
    css_pkg::pos_t   pos;
    logic            lc_ok;
    logic            byte_eq;
    logic            ovf_eff;
    css_pkg::ix_t    len_eff;
    css_pkg::ix_t    r_eff;
    logic [8:0]      rv;
    logic            first;
    css_pkg::ix_t    dsel;

    assign take      = (state_reg == css_pkg::ST_IDLE) && item_valid && room2;
    assign itm_pat   = (item.kind == css_pkg::K_PAT) || (item.kind == css_pkg::K_PAT_LAST);
    assign itm_last  = (item.kind == css_pkg::K_PAT_LAST) || (item.kind == css_pkg::K_TEXT_LAST);
    assign searching = (phase_reg == css_pkg::PH_SEARCH);
    assign rc_room   = !rc_reg[css_pkg::POS_W-1];
    assign rc_after  = (searching && rc_room) ? rc_reg + 1'b1 : rc_reg;
    assign win       = searching &&
                       (({1'b0, ws_reg} + {13'b0, len_reg}) <= {1'b0, rc_after});
    assign ovf_eff   = ovf_reg | (searching & ~rc_room);
    assign hq_sum    = {1'b0, hmax_rd} + {1'b0, k_reg};
    assign hq_less   = hq_sum < {1'b0, a_reg};
    assign pos       = ws_reg + {13'b0, visit_rd};
    assign lc_ok     = lcp_reg <= pos;
    assign byte_eq   = (pat_rd0 == ring_rd);
    assign len_eff   = (phase_reg != css_pkg::PH_LOAD) ? '0 : len_reg;
    assign r_eff     = (hmax_rd == len_reg) ? a_reg : r_reg;
    assign rv        = (kmin_rd == '0) ? r_eff : '0;
    assign first     = (a_reg < fpe_reg);
    assign dsel      = first ? ({1'b0, v_reg} - kmin_rd) : (len_reg - rmin_rd);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            css_pkg::ST_IDLE:
            begin
                if (take)
                begin
                    if (itm_pat)
                    begin
                        if (itm_last)
                        begin
                            state_next = css_pkg::ST_CLR;
                        end
                    end
                    else if (win)
                    begin
                        state_next = css_pkg::ST_SEA_V;
                    end
                end
            end
            css_pkg::ST_CLR:
            begin
                if (a_reg + 9'd1 == len_reg)
                begin
                    state_next = css_pkg::ST_HA_RD;
                end
            end
            css_pkg::ST_HA_RD:
                state_next = (a_reg < len_reg) ? css_pkg::ST_HA_CMP : css_pkg::ST_HW;
            css_pkg::ST_HA_CMP:
                state_next = (pat_rd0 == pat_rd1) ? css_pkg::ST_HA_RD : css_pkg::ST_HW;
            css_pkg::ST_HW:
                state_next = css_pkg::ST_HQ_RD;
            css_pkg::ST_HQ_RD:
                state_next = (q_reg <= len_reg) ? css_pkg::ST_HQ_CMP : css_pkg::ST_HEND;
            css_pkg::ST_HQ_CMP:
                state_next = hq_less ? css_pkg::ST_HQ_RD : css_pkg::ST_HEND;
            css_pkg::ST_HEND:
                state_next = (q_reg <= len_reg) ? css_pkg::ST_HA_RD : css_pkg::ST_KM_RD;
            css_pkg::ST_KM_RD:
                state_next = css_pkg::ST_KM_WR;
            css_pkg::ST_KM_WR:
                state_next = (a_reg == 9'd1) ? css_pkg::ST_RM_RD : css_pkg::ST_KM_RD;
            css_pkg::ST_RM_RD:
                state_next = css_pkg::ST_RM_WR;
            css_pkg::ST_RM_WR:
                state_next = (a_reg == 9'd1) ? css_pkg::ST_VO_RD : css_pkg::ST_RM_RD;
            css_pkg::ST_VO_RD:
                state_next = css_pkg::ST_VO_WR;
            css_pkg::ST_VO_WR:
                state_next = (a_reg + 9'd1 == len_reg) ? css_pkg::ST_NHD_LAST
                                                       : css_pkg::ST_VO_RD;
            css_pkg::ST_NHD_LAST:
                state_next = css_pkg::ST_SR_VIS;
            css_pkg::ST_SR_VIS:
                state_next = css_pkg::ST_SR_TAB;
            css_pkg::ST_SR_TAB:
                state_next = css_pkg::ST_SR_NHD;
            css_pkg::ST_SR_NHD:
                state_next = css_pkg::ST_SR_WR;
            css_pkg::ST_SR_WR:
                state_next = (a_reg == len_reg) ? css_pkg::ST_IDLE : css_pkg::ST_SR_VIS;
            css_pkg::ST_SEA_V:
                state_next = (i_reg < len_reg) ? css_pkg::ST_SEA_C : css_pkg::ST_SEA_T;
            css_pkg::ST_SEA_C:
                state_next = lc_ok ? css_pkg::ST_SEA_D : css_pkg::ST_SEA_T;
            css_pkg::ST_SEA_D:
                state_next = byte_eq ? css_pkg::ST_SEA_V : css_pkg::ST_SEA_T;
            css_pkg::ST_SEA_T:
                state_next = css_pkg::ST_SEA_U;
            css_pkg::ST_SEA_U:
                state_next = css_pkg::ST_IDLE;
            default:
                state_next = css_pkg::ST_IDLE;
        endcase
    end

    // Register updates, memory accesses and result pushes.
    always_comb
    begin
        phase_next = phase_reg;
        len_next   = len_reg;
        fpe_next   = fpe_reg;
        ws_next    = ws_reg;
        rc_next    = rc_reg;
        lcp_next   = lcp_reg;
        sp_next    = sp_reg;
        ovf_next   = ovf_reg;
        last_next  = last_reg;
        i_next     = i_reg;
        a_next     = a_reg;
        k_next     = k_reg;
        q_next     = q_reg;
        r_next     = r_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        v_next     = v_reg;
        rmin0_next = rmin0_reg;

        pat_we    = 1'b0; pat_wa    = '0; pat_wd    = '0; pat_ra0 = '0; pat_ra1 = '0;
        ring_we   = 1'b0; ring_wa   = '0; ring_wd   = '0; ring_ra = '0;
        hmax_we   = 1'b0; hmax_wa   = '0; hmax_wd   = '0; hmax_ra = '0;
        kmin_we   = 1'b0; kmin_wa   = '0; kmin_wd   = '0; kmin_ra = '0;
        rmin_we   = 1'b0; rmin_wa   = '0; rmin_wd   = '0; rmin_ra = '0;
        visit_we  = 1'b0; visit_wa  = '0; visit_wd  = '0; visit_ra = '0;
        nhd_we    = 1'b0; nhd_wa    = '0; nhd_wd    = '0; nhd_ra = '0;
        shift_we  = 1'b0; shift_wa  = '0; shift_wd  = '0; shift_ra = '0;
        resume_we = 1'b0; resume_wa = '0; resume_wd = '0; resume_ra = '0;

        res_push = 1'b0;
        res_data = '0;

        unique case (state_reg)
            css_pkg::ST_IDLE:
            begin
                if (take)
                begin
                    if (itm_pat)
                    begin
                        // Pattern byte: restart the pattern if one was not loading.
                        phase_next = css_pkg::PH_LOAD;
                        len_next   = len_eff;
                        if (!len_eff[8])
                        begin
                            pat_we   = 1'b1;
                            pat_wa   = len_eff[7:0];
                            pat_wd   = item.ch;
                            len_next = len_eff + 9'd1;
                        end
                        if (itm_last)
                        begin
                            phase_next = css_pkg::PH_SEARCH;
                            a_next     = '0;
                            ws_next    = '0;
                            rc_next    = '0;
                            lcp_next   = '0;
                            sp_next    = '0;
                            ovf_next   = 1'b0;
                        end
                    end
                    else
                    begin
                        // Text byte: store it in the ring while positions remain.
                        if (searching)
                        begin
                            if (rc_room)
                            begin
                                ring_we = 1'b1;
                                ring_wa = rc_reg[7:0];
                                ring_wd = item.ch;
                                rc_next = rc_after;
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        if (win)
                        begin
                            last_next = itm_last;
                            i_next    = (sp_reg > len_reg) ? len_reg : sp_reg;
                        end
                        else if (itm_last)
                        begin
                            res_push           = 1'b1;
                            res_data.text_done = 1'b1;
                            res_data.overflow  = ovf_eff;
                            ws_next  = '0;
                            rc_next  = '0;
                            lcp_next = '0;
                            sp_next  = '0;
                            ovf_next = 1'b0;
                        end
                    end
                end
            end

            // Clear the minimum-period row before it is filled.
            css_pkg::ST_CLR:
            begin
                kmin_we = 1'b1;
                kmin_wa = a_reg[7:0];
                kmin_wd = '0;
                a_next  = a_reg + 9'd1;
                if (a_reg + 9'd1 == len_reg)
                begin
                    a_next = 9'd1;
                    k_next = 9'd1;
                end
            end

            // Extend the match of the pattern against itself shifted by k.
            css_pkg::ST_HA_RD:
            begin
                pat_ra0 = a_reg[7:0];
                pat_ra1 = 8'(a_reg - k_reg);
            end
            css_pkg::ST_HA_CMP:
            begin
                if (pat_rd0 == pat_rd1)
                begin
                    a_next = a_reg + 9'd1;
                end
            end
            css_pkg::ST_HW:
            begin
                hmax_we = 1'b1;
                hmax_wa = k_reg;
                hmax_wd = a_reg;
                q_next  = k_reg + 9'd1;
            end

            // Copy earlier periods forward while they stay short of a.
            css_pkg::ST_HQ_RD:
            begin
                hmax_ra = q_reg - k_reg;
            end
            css_pkg::ST_HQ_CMP:
            begin
                if (hq_less)
                begin
                    hmax_we = 1'b1;
                    hmax_wa = q_reg;
                    hmax_wd = hq_sum[8:0];
                    q_next  = q_reg + 9'd1;
                end
            end
            css_pkg::ST_HEND:
            begin
                k_next = q_reg;
                if (q_reg == a_reg + 9'd1)
                begin
                    a_next = q_reg;
                end
                if (q_reg > len_reg)
                begin
                    a_next = len_reg;
                end
            end

            // Minimum shift for each mismatch position, scanning downwards.
            css_pkg::ST_KM_RD:
            begin
                hmax_ra = a_reg;
            end
            css_pkg::ST_KM_WR:
            begin
                if (hmax_rd < len_reg)
                begin
                    kmin_we = 1'b1;
                    kmin_wa = hmax_rd[7:0];
                    kmin_wd = a_reg;
                end
                a_next = a_reg - 9'd1;
                if (a_reg == 9'd1)
                begin
                    a_next = len_reg;
                    r_next = len_reg;
                end
            end

            // Resume shifts for the positions without a minimum shift.
            css_pkg::ST_RM_RD:
            begin
                hmax_ra = a_reg;
                kmin_ra = 8'(a_reg - 9'd1);
            end
            css_pkg::ST_RM_WR:
            begin
                r_next  = r_eff;
                rmin_we = 1'b1;
                rmin_wa = 8'(a_reg - 9'd1);
                rmin_wd = rv;
                a_next  = a_reg - 9'd1;
                if (a_reg == 9'd1)
                begin
                    rmin0_next = rv;
                    a_next     = '0;
                    lo_next    = '0;
                    hi_next    = len_reg;
                end
            end

            // Visit order: special positions first, the rest from the top down.
            css_pkg::ST_VO_RD:
            begin
                kmin_ra = a_reg[7:0];
            end
            css_pkg::ST_VO_WR:
            begin
                nhd_we   = 1'b1;
                nhd_wa   = a_reg;
                nhd_wd   = lo_reg;
                visit_we = 1'b1;
                visit_wd = a_reg[7:0];
                if (kmin_rd == '0)
                begin
                    visit_wa = 8'(hi_reg - 9'd1);
                    hi_next  = hi_reg - 9'd1;
                end
                else
                begin
                    visit_wa = lo_reg[7:0];
                    lo_next  = lo_reg + 9'd1;
                end
                a_next = a_reg + 9'd1;
            end
            css_pkg::ST_NHD_LAST:
            begin
                nhd_we   = 1'b1;
                nhd_wa   = len_reg;
                nhd_wd   = lo_reg;
                fpe_next = lo_reg;
                a_next   = '0;
            end

            // Shift and resume tables, one visit position at a time.
            css_pkg::ST_SR_VIS:
            begin
                visit_ra = (a_reg == len_reg) ? 8'(len_reg - 9'd1) : a_reg[7:0];
            end
            css_pkg::ST_SR_TAB:
            begin
                v_next  = visit_rd;
                kmin_ra = visit_rd;
                rmin_ra = visit_rd;
            end
            css_pkg::ST_SR_NHD:
            begin
                shift_we = 1'b1;
                shift_wa = a_reg;
                if (a_reg == len_reg)
                begin
                    shift_wd = rmin0_reg;
                end
                else
                begin
                    shift_wd = first ? kmin_rd : rmin_rd;
                end
                nhd_ra = dsel;
            end
            css_pkg::ST_SR_WR:
            begin
                resume_we = 1'b1;
                resume_wa = a_reg;
                resume_wd = nhd_rd;
                a_next    = a_reg + 9'd1;
            end

            // Window search.
            css_pkg::ST_SEA_V:
            begin
                visit_ra = i_reg[7:0];
                if (i_reg >= len_reg)
                begin
                    res_push             = 1'b1;
                    res_data.found       = 1'b1;
                    res_data.match_start = ws_reg[19:0];
                    res_data.overflow    = ovf_reg;
                    i_next               = len_reg;
                end
            end
            css_pkg::ST_SEA_C:
            begin
                pat_ra0 = visit_rd;
                ring_ra = pos[7:0];
                if (!lc_ok)
                begin
                    res_push             = 1'b1;
                    res_data.found       = 1'b1;
                    res_data.match_start = ws_reg[19:0];
                    res_data.overflow    = ovf_reg;
                    i_next               = len_reg;
                end
            end
            css_pkg::ST_SEA_D:
            begin
                if (byte_eq)
                begin
                    i_next = i_reg + 9'd1;
                end
            end
            css_pkg::ST_SEA_T:
            begin
                shift_ra  = i_reg;
                resume_ra = i_reg;
                if (i_reg >= fpe_reg)
                begin
                    lcp_next = ws_reg + {12'b0, len_reg};
                end
            end
            css_pkg::ST_SEA_U:
            begin
                ws_next = ws_reg + {12'b0, shift_rd};
                sp_next = resume_rd;
                if (last_reg)
                begin
                    res_push           = 1'b1;
                    res_data.text_done = 1'b1;
                    res_data.overflow  = ovf_reg;
                    ws_next  = '0;
                    rc_next  = '0;
                    lcp_next = '0;
                    sp_next  = '0;
                    ovf_next = 1'b0;
                end
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    // Memories.
    always_ff @(posedge clk)
    begin
        if (pat_we)
        begin
            pat_mem[pat_wa] <= pat_wd;
        end
        pat_rd0 <= pat_mem[pat_ra0];
        pat_rd1 <= pat_mem[pat_ra1];
    end

    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem[ring_wa] <= ring_wd;
        end
        ring_rd <= ring_mem[ring_ra];
    end

    always_ff @(posedge clk)
    begin
        if (hmax_we)
        begin
            hmax_mem[hmax_wa] <= hmax_wd;
        end
        hmax_rd <= hmax_mem[hmax_ra];
    end

    always_ff @(posedge clk)
    begin
        if (kmin_we)
        begin
            kmin_mem[kmin_wa] <= kmin_wd;
        end
        kmin_rd <= kmin_mem[kmin_ra];
    end

    always_ff @(posedge clk)
    begin
        if (rmin_we)
        begin
            rmin_mem[rmin_wa] <= rmin_wd;
        end
        rmin_rd <= rmin_mem[rmin_ra];
    end

    always_ff @(posedge clk)
    begin
        if (visit_we)
        begin
            visit_mem[visit_wa] <= visit_wd;
        end
        visit_rd <= visit_mem[visit_ra];
    end

    always_ff @(posedge clk)
    begin
        if (nhd_we)
        begin
            nhd_mem[nhd_wa] <= nhd_wd;
        end
        nhd_rd <= nhd_mem[nhd_ra];
    end

    always_ff @(posedge clk)
    begin
        if (shift_we)
        begin
            shift_mem[shift_wa] <= shift_wd;
        end
        shift_rd <= shift_mem[shift_ra];
    end

    always_ff @(posedge clk)
    begin
        if (resume_we)
        begin
            resume_mem[resume_wa] <= resume_wd;
        end
        resume_rd <= resume_mem[resume_ra];
    end

    // Build scratch registers and the search index and last flag carry no reset.
    always_ff @(posedge clk)
    begin
        a_reg     <= a_next;
        k_reg     <= k_next;
        q_reg     <= q_next;
        r_reg     <= r_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        v_reg     <= v_next;
        rmin0_reg <= rmin0_next;
        i_reg     <= i_next;
        last_reg  <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= css_pkg::ST_IDLE;
            phase_reg <= css_pkg::PH_IDLE;
            len_reg   <= '0;
            fpe_reg   <= '0;
            ws_reg    <= '0;
            rc_reg    <= '0;
            lcp_reg   <= '0;
            sp_reg    <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            len_reg   <= len_next;
            fpe_reg   <= fpe_next;
            ws_reg    <= ws_next;
            rc_reg    <= rc_next;
            lcp_reg   <= lcp_next;
            sp_reg    <= sp_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule

[test/tb_colussi_string_search.sv]
// ----------------------------------------------------------------------------
// tb_colussi_string_search
// Self-checking testbench for the Colussi exact string search block.
// ----------------------------------------------------------------------------
// Pattern and text bytes are queued by the stimulus process and pushed by a
// bursty driver. Each accepted byte is fed to a predictor that keeps its own
// copy of the search tables and text window. A monitor compares every popped
// result, field by field, with the oldest predicted one. The result side
// stalls on a changing pattern, and once holds off for a long stretch so that
// the block fills up and stops taking input.
// ----------------------------------------------------------------------------
module tb_colussi_string_search;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  PLEN_MAX = 256;
    localparam longint TEXT_LIMIT = 64'd1048576;
    localparam int  ITEM_TARGET = 1250;
    localparam int  DRAIN_CYCLES = 300;
    localparam int  HOLD_START = 3000;
    localparam int  HOLD_LEN = 1500;

    typedef struct {
        logic       op;
        logic [7:0] ch;
        logic       last;
    } byte_item_t;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic        op;
    logic [7:0]  ch;
    logic        is_last;
    logic        empty;
    logic        pop;
    logic        found;
    logic [19:0] match_start;
    logic        text_done;
    logic        overflow;

    colussi_string_search uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .op          (op),
        .ch          (ch),
        .is_last     (is_last),
        .empty       (empty),
        .pop         (pop),
        .found       (found),
        .match_start (match_start),
        .text_done   (text_done),
        .overflow    (overflow)
    );

    // Stimulus and expectation stores.
    byte_item_t         pending_bytes[$];
    css_pkg::res_t      expected_results[$];
    int                 errors = 0;
    int                 cycle_count = 0;
    bit                 byte_taken = 0;
    bit                 hold_off = 0;

    // Predictor state.
    logic [7:0] pat_mem [0:PLEN_MAX-1];
    int         visit_ord [0:PLEN_MAX];
    int         resume_ix [0:PLEN_MAX];
    int         shift_by [0:PLEN_MAX];
    logic [7:0] text_ring [0:PLEN_MAX-1];
    int         pat_len = 0;
    int         first_end = 0;
    longint     win_start = 0;
    longint     rcv_count = 0;
    longint     last_chk = -1;
    int         scan_pos = 0;
    css_pkg::phase_t search_phase = css_pkg::PH_IDLE;
    bit         ovf_flag = 0;

    // Clock.
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Clamp a table index; negative values stand for an unsigned wrap.
    function automatic int clamp_ix(int v);
        if (v < 0 || v > PLEN_MAX)
            return PLEN_MAX;
        return v;
    endfunction

    // Two pattern positions compare equal; positions off the pattern never do.
    function automatic bit pat_same(int a, int b);
        return a >= 0 && b >= 0 && a < pat_len && b < pat_len && pat_mem[a] == pat_mem[b];
    endfunction

    function automatic void reset_text();
        win_start = 0;
        rcv_count = 0;
        last_chk = -1;
        scan_pos = 0;
        ovf_flag = 0;
    endfunction

    // Build the visit order, shift and resume tables for the stored pattern.
    function automatic void build_search_tables();
        int hmax [0:PLEN_MAX+1];
        int kmin [0:PLEN_MAX+1];
        int rmin [0:PLEN_MAX+1];
        int nhd0 [0:PLEN_MAX+1];
        int m;
        int a;
        int k;
        int q;
        int r;
        int cnt;
        int lo;
        int hi;
        int v;
        int d;
        m = pat_len;
        for (int z = 0; z <= PLEN_MAX + 1; z++)
        begin
            hmax[z] = 0;
            kmin[z] = 0;
            rmin[z] = 0;
            nhd0[z] = 0;
        end
        a = 1;
        k = 1;
        do
        begin
            while (a < m && pat_same(a, a - k))
                a++;
            hmax[clamp_ix(k)] = a;
            q = k + 1;
            while (q <= m && q > k && hmax[clamp_ix(q - k)] + k < a)
            begin
                hmax[clamp_ix(q)] = hmax[clamp_ix(q - k)] + k;
                q++;
            end
            k = q;
            if (k == a + 1)
                a = k;
        end while (k <= m);

        for (a = m; a >= 1; a--)
            if (hmax[a] < m)
                kmin[clamp_ix(hmax[a])] = a;

        r = m;
        for (a = m; a >= 1; a--)
        begin
            if (hmax[a] == m)
                r = a;
            rmin[a - 1] = (kmin[a - 1] == 0) ? r : 0;
        end

        lo = 0;
        hi = m;
        for (a = 0; a < m; a++)
        begin
            if (kmin[a] == 0)
            begin
                hi--;
                visit_ord[hi] = a;
            end
            else
            begin
                visit_ord[lo] = a;
                lo++;
            end
        end
        first_end = lo;

        for (a = 0; a < m; a++)
            shift_by[a] = (a < lo) ? kmin[visit_ord[a]] : rmin[visit_ord[a]];
        shift_by[m] = rmin[0];

        cnt = 0;
        for (a = 0; a < m; a++)
        begin
            nhd0[a] = cnt;
            if (kmin[a] > 0)
                cnt++;
        end
        nhd0[m] = cnt;

        for (a = 0; a < m; a++)
        begin
            v = visit_ord[a];
            d = (a < lo) ? v - kmin[v] : m - rmin[v];
            resume_ix[a] = nhd0[clamp_ix(d)];
        end
        resume_ix[m] = nhd0[clamp_ix(m - rmin[visit_ord[m - 1]])];
    endfunction

    // Work out the results caused by one accepted byte.
    function automatic void predict_search(logic b_op, logic [7:0] b_ch, logic b_last);
        css_pkg::res_t res;
        longint j;
        int     i;
        int     m;
        if (b_op == css_pkg::OP_PAT)
        begin
            if (search_phase != css_pkg::PH_LOAD)
            begin
                pat_len = 0;
                search_phase = css_pkg::PH_LOAD;
            end
            if (pat_len < PLEN_MAX)
            begin
                pat_mem[pat_len] = b_ch;
                pat_len++;
            end
            if (b_last)
            begin
                build_search_tables();
                search_phase = css_pkg::PH_SEARCH;
                reset_text();
            end
            return;
        end

        if (search_phase == css_pkg::PH_SEARCH)
        begin
            m = pat_len;
            if (rcv_count < TEXT_LIMIT)
            begin
                text_ring[rcv_count % PLEN_MAX] = b_ch;
                rcv_count++;
            end
            else
                ovf_flag = 1;
            if (win_start + m <= rcv_count)
            begin
                j = win_start;
                i = (scan_pos > m) ? m : scan_pos;
                while (i < m && last_chk < j + visit_ord[i] &&
                       pat_mem[visit_ord[i]] == text_ring[(j + visit_ord[i]) % PLEN_MAX])
                    i++;
                if (i >= m || last_chk >= j + visit_ord[i])
                begin
                    res.found = 1'b1;
                    res.match_start = j[19:0];
                    res.text_done = 1'b0;
                    res.overflow = ovf_flag;
                    expected_results.push_back(res);
                    i = m;
                end
                if (i >= first_end)
                    last_chk = j + m - 1;
                win_start = j + shift_by[i];
                scan_pos = resume_ix[i];
            end
        end

        if (b_last)
        begin
            res.found = 1'b0;
            res.match_start = '0;
            res.text_done = 1'b1;
            res.overflow = ovf_flag;
            expected_results.push_back(res);
            reset_text();
        end
    endfunction

    // Monitor: predict on accepted bytes and check accepted results.
    always @(posedge clk)
    begin
        css_pkg::res_t exp_res;
        cycle_count++;
        byte_taken = rst_n && push && !full;
        if (rst_n && pop && !empty)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result: found=%0d match_start=%0d text_done=%0d",
                       found, match_start, text_done);
                errors++;
            end
            else
            begin
                exp_res = expected_results.pop_front();
                if (found !== exp_res.found)
                begin
                    $error("found: expected %0d, got %0d", exp_res.found, found);
                    errors++;
                end
                if (match_start !== exp_res.match_start)
                begin
                    $error("match_start: expected %0d, got %0d",
                           exp_res.match_start, match_start);
                    errors++;
                end
                if (text_done !== exp_res.text_done)
                begin
                    $error("text_done: expected %0d, got %0d", exp_res.text_done, text_done);
                    errors++;
                end
                if (overflow !== exp_res.overflow)
                begin
                    $error("overflow: expected %0d, got %0d", exp_res.overflow, overflow);
                    errors++;
                end
            end
        end
        if (byte_taken)
            predict_search(op, ch, is_last);
    end

    // Driver: offers queued bytes in bursts with random gaps.
    always @(negedge clk)
    begin
        static int burst_left = 0;
        static int gap_left = 0;
        logic next_push;
        next_push = 1'b0;
        if (byte_taken)
            void'(pending_bytes.pop_front());
        if (gap_left > 0)
            gap_left--;
        else if (rst_n && pending_bytes.size() > 0)
        begin
            next_push = 1'b1;
            op <= pending_bytes[0].op;
            ch <= pending_bytes[0].ch;
            is_last <= pending_bytes[0].last;
            if (burst_left > 0)
                burst_left--;
            else
            begin
                burst_left = $urandom_range(1, 60);
                gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            end
        end
        push <= next_push;
    end

    // Long hold-off of the result side, counted in its own process.
    always @(posedge clk)
    begin
        static int hold_count = 0;
        if (rst_n)
            hold_count++;
        hold_off <= (hold_count >= HOLD_START && hold_count < HOLD_START + HOLD_LEN);
    end

    // Receiver: the stall rate changes between four randomly chosen modes.
    always @(negedge clk)
    begin
        static int stall_mode = 0;
        if (cycle_count % 400 == 0)
            stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0:       pop <= !hold_off;
            1:       pop <= !hold_off && ($urandom_range(0, 3) != 0);
            2:       pop <= !hold_off && ($urandom_range(0, 3) == 0);
            default: pop <= !hold_off && ((cycle_count / 7) % 2 == 0);
        endcase
    end

    task automatic add_byte(logic b_op, logic [7:0] b_ch, logic b_last);
        byte_item_t it;
        it.op = b_op;
        it.ch = b_ch;
        it.last = b_last;
        pending_bytes.push_back(it);
    endtask

    // Byte from a small alphabet so that matches are frequent.
    function automatic logic [7:0] pick_char(logic [7:0] base, int spread);
        return base ^ 8'($urandom_range(0, spread));
    endfunction

    // Stimulus.
    initial
    begin
        logic [7:0] base;
        int         spread;
        int         plen;
        int         tlen;
        int         texts;
        int         choice;
        string      demo_text;
        push = 1'b0;
        pop = 1'b0;
        op = css_pkg::OP_PAT;
        ch = 8'h00;
        is_last = 1'b0;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Text with no pattern loaded, a one-byte pattern at the byte extremes,
        // a periodic pattern, a new pattern cutting into text, a one-byte text.
        add_byte(css_pkg::OP_TEXT, 8'h41, 1'b0);
        add_byte(css_pkg::OP_TEXT, 8'h42, 1'b1);
        add_byte(css_pkg::OP_PAT, 8'hFF, 1'b1);
        add_byte(css_pkg::OP_TEXT, 8'hFF, 1'b0);
        add_byte(css_pkg::OP_TEXT, 8'h00, 1'b0);
        add_byte(css_pkg::OP_TEXT, 8'hFF, 1'b1);
        add_byte(css_pkg::OP_PAT, 8'h61, 1'b0);
        add_byte(css_pkg::OP_PAT, 8'h62, 1'b0);
        add_byte(css_pkg::OP_PAT, 8'h61, 1'b1);
        demo_text = "ababababa";
        for (int idx = 0; idx < demo_text.len(); idx++)
            add_byte(css_pkg::OP_TEXT, demo_text[idx], idx == demo_text.len() - 1);
        add_byte(css_pkg::OP_TEXT, 8'h61, 1'b0);
        add_byte(css_pkg::OP_PAT, 8'h00, 1'b0);
        add_byte(css_pkg::OP_PAT, 8'h00, 1'b1);
        add_byte(css_pkg::OP_TEXT, 8'h00, 1'b0);
        add_byte(css_pkg::OP_TEXT, 8'h00, 1'b0);
        add_byte(css_pkg::OP_TEXT, 8'h00, 1'b1);
        add_byte(css_pkg::OP_TEXT, 8'h00, 1'b1);

        // Random sessions: a pattern followed by one to four texts.
        while (pending_bytes.size() < ITEM_TARGET)
        begin
            base = 8'($urandom);
            spread = ($urandom_range(0, 3) == 0) ? 3 : 1;
            choice = $urandom_range(0, 39);
            if (choice == 0)
                plen = $urandom_range(250, 300);
            else if (choice < 6)
                plen = $urandom_range(9, 24);
            else
                plen = $urandom_range(1, 8);
            for (int p = 0; p < plen; p++)
                add_byte(css_pkg::OP_PAT, pick_char(base, spread), p == plen - 1);
            texts = $urandom_range(1, 4);
            for (int t = 0; t < texts; t++)
            begin
                choice = $urandom_range(0, 19);
                tlen = (choice == 0) ? $urandom_range(260, 320) : $urandom_range(1, 50);
                for (int c = 0; c < tlen; c++)
                begin
                    // Occasional noise byte from the whole range.
                    if ($urandom_range(0, 15) == 0)
                        add_byte(css_pkg::OP_TEXT, 8'($urandom), c == tlen - 1);
                    else
                        add_byte(css_pkg::OP_TEXT, pick_char(base, spread), c == tlen - 1);
                end
            end
            // Now and then a text is left open and cut by the next pattern.
            if ($urandom_range(0, 4) == 0)
                for (int c = 0; c < 5; c++)
                    add_byte(css_pkg::OP_TEXT, pick_char(base, spread), 1'b0);
        end
        add_byte(css_pkg::OP_TEXT, 8'h5A, 1'b1);

        // Drain.
        while (pending_bytes.size() > 0 || expected_results.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("colussi_string_search test passed");
        else
            $display("colussi_string_search test failed");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #20ms;
        $display("colussi_string_search test failed");
        $finish;
    end

endmodule
